// ----- sv/exvr_pkg.sv -----
// shared types, widths and constants for the xyz euler vector rotation unit
// holds the request structs, fixed-point widths and the sine polynomial coefficients
// no dependencies
package exvr_pkg;

	localparam int COORD_W = 32;
	localparam int ANGLE_W = 16;
	localparam int TRIG_W  = 32;
	localparam int WIDE_W  = 34;
	localparam int PROD_W  = WIDE_W + COORD_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int CFG_IDX_W = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z = 2'd2;

	// q2.30 fixed point
	localparam logic [30:0] TRIG_ONE_U   = 31'd1073741824;
	localparam logic [60:0] TRIG_HALF_U  = 61'd536870912;
	localparam logic [ANGLE_W-1:0] ANGLE_QUARTER = 16'd16384;

	// horner coefficients of sin(pi/2 * t), q30
	localparam logic [30:0] K1  = 31'd1686629713;
	localparam logic [30:0] K3  = 31'd693598668;
	localparam logic [30:0] K5  = 31'd85569306;
	localparam logic [30:0] K7  = 31'd5026995;
	localparam logic [30:0] K9  = 31'd172272;
	localparam logic [30:0] K11 = 31'd3864;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
	} coord_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] rot_x;
		logic signed [COORD_W-1:0] rot_y;
		logic signed [COORD_W-1:0] rot_z;
	} rot_out_t;

	// coefficient subtracted at each horner step
	function automatic logic [30:0] horner_coef(input logic [2:0] step);
		logic [30:0] k;
		case (step)
			3'd1:    k = K9;
			3'd2:    k = K7;
			3'd3:    k = K5;
			3'd4:    k = K3;
			3'd5:    k = K1;
			default: k = K11;
		endcase
		return k;
	endfunction

	// floor((v + 2^29) / 2^30), kept to the wide coordinate width
	function automatic logic signed [WIDE_W-1:0] round_q30(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] w;
		logic signed [SUM_W-1:0] sh;
		w  = v + SUM_W'(TRIG_HALF_U);
		sh = w >>> 30;
		return sh[WIDE_W-1:0];
	endfunction

	// clamp a wide coordinate to the 32-bit range
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > WIDE_W'(34'sd2147483647)) begin
			r = 32'sh7fffffff;
		end else if (v < -WIDE_W'(34'sd2147483648)) begin
			r = 32'sh80000000;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- sv/euler_xyz_vector_rotation_unit.sv -----
// top level of the xyz euler vector rotation unit
// holds the angle registers, the shared sine/cosine sequencer and the rotation pipeline
// depends on exvr_pkg
//
// usage:
// - input channel in_valid / in_ready / in_data carries one point (coord_x/y/z, q16.16)
// - output channel out_valid / out_ready / out_data carries the rotated point, rotated
//   about x, then y, then z, each coordinate saturated to 32 bits
// - angles are written through cfg_we / cfg_index / cfg_data (index 0 x, 1 y, 2 z);
//   a write to index 3 is ignored
// - after reset or an angle write the sine/cosine sequencer runs
//   (6 values, 7 steps of one shared 31x30 multiplier each); in_ready stays low meanwhile
// - a request passes stages s1 to s7 before out_valid; throughput is one request per
//   cycle when not busy and not stalled, set by the seven-stage rotation pipeline
// - each stage advances when its successor has room, so bubbles close up; when the
//   receiver stalls the pipeline fills and then in_ready drops, nothing lost or repeated
// - reset clears the angles to zero and empties the pipeline
module euler_xyz_vector_rotation_unit
	import exvr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ANGLE_W-1:0]   cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  coord_in_t            in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rot_out_t             out_data
);

	// angle registers
	logic [ANGLE_W-1:0] angle_q [3];
	logic cfg_hit;
	assign cfg_hit = cfg_we && (cfg_index == REG_ANGLE_X || cfg_index == REG_ANGLE_Y ||
		cfg_index == REG_ANGLE_Z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q[0] <= '0;
			angle_q[1] <= '0;
			angle_q[2] <= '0;
		end else if (cfg_hit) begin
			angle_q[cfg_index] <= cfg_data;
		end
	end

	// sine/cosine sequencer: tidx picks angle (upper bits) and sin/cos (lsb)
	logic        busy_q;
	logic [2:0]  tidx_q;
	logic [2:0]  step_q;
	logic [29:0] s_q;
	logic [30:0] p_q;
	logic signed [TRIG_W-1:0] sin_q [3];
	logic signed [TRIG_W-1:0] cos_q [3];

	logic [ANGLE_W-1:0] ang;
	logic [1:0]  quad;
	logic [13:0] rem;
	logic [14:0] fold;
	logic [29:0] targ;
	logic [30:0] mul_a;
	logic [29:0] mul_b;
	logic [60:0] mul_p;
	logic [30:0] qres;
	logic [30:0] mag;
	logic signed [TRIG_W-1:0] trig_val;

	always_comb begin
		ang  = angle_q[tidx_q[2:1]] + (tidx_q[0] ? ANGLE_QUARTER : '0);
		quad = ang[15:14];
		rem  = ang[13:0];
		fold = quad[0] ? (15'd16384 - {1'b0, rem}) : {1'b0, rem};
		targ = {fold[13:0], 16'b0};
		case (step_q)
			3'd0: begin
				mul_a = {1'b0, targ};
				mul_b = targ;
			end
			3'd6: begin
				mul_a = p_q;
				mul_b = targ;
			end
			default: begin
				mul_a = p_q;
				mul_b = s_q;
			end
		endcase
		mul_p = mul_a * mul_b;
		qres  = 31'((mul_p + TRIG_HALF_U) >> 30);
		// exact quarter turn, else clamp to one
		if (fold[14] || qres > TRIG_ONE_U) begin
			mag = TRIG_ONE_U;
		end else begin
			mag = qres;
		end
		trig_val = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			tidx_q <= '0;
			step_q <= '0;
		end else if (cfg_hit) begin
			busy_q <= 1'b1;
			tidx_q <= '0;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == 3'd6) begin
				step_q <= '0;
				if (tidx_q == 3'd5) begin
					busy_q <= 1'b0;
				end else begin
					tidx_q <= tidx_q + 3'd1;
				end
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (step_q == 3'd0) begin
				s_q <= qres[29:0];
				p_q <= K11;
			end else if (step_q == 3'd6) begin
				if (tidx_q[0]) begin
					cos_q[tidx_q[2:1]] <= trig_val;
				end else begin
					sin_q[tidx_q[2:1]] <= trig_val;
				end
			end else begin
				p_q <= horner_coef(step_q) - qres;
			end
		end
	end

	// stage enables, each stage moves when its successor has room
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;
	logic accept;
	assign en7 = !v_s7 || out_ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1 && !busy_q;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= accept;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// rotation pipeline: p' = p*c - q*s, q' = p*s + q*c
	logic signed [PROD_W-1:0] pc_s1, qs_s1, ps_s1, qc_s1;
	logic signed [PROD_W-1:0] pc_s3, qs_s3, ps_s3, qc_s3;
	logic signed [PROD_W-1:0] pc_s5, qs_s5, ps_s5, qc_s5;
	logic signed [WIDE_W-1:0] x_s1, x_s2, y_s2, z_s2;
	logic signed [WIDE_W-1:0] y_s3, x_s4, y_s4, z_s4;
	logic signed [WIDE_W-1:0] z_s5, x_s6, y_s6, z_s6;
	logic signed [WIDE_W-1:0] in_x, in_y, in_z;
	rot_out_t out_s7;

	assign in_x = WIDE_W'(in_data.coord_x);
	assign in_y = WIDE_W'(in_data.coord_y);
	assign in_z = WIDE_W'(in_data.coord_z);

	always_ff @(posedge clk) begin
		// x rotation products, p = y, q = z
		if (en1) begin
			pc_s1 <= in_y * cos_q[0];
			qs_s1 <= in_z * sin_q[0];
			ps_s1 <= in_y * sin_q[0];
			qc_s1 <= in_z * cos_q[0];
			x_s1  <= in_x;
		end
		if (en2) begin
			y_s2 <= round_q30(SUM_W'(pc_s1) - SUM_W'(qs_s1));
			z_s2 <= round_q30(SUM_W'(ps_s1) + SUM_W'(qc_s1));
			x_s2 <= x_s1;
		end
		// y rotation products, p = z, q = x
		if (en3) begin
			pc_s3 <= z_s2 * cos_q[1];
			qs_s3 <= x_s2 * sin_q[1];
			ps_s3 <= z_s2 * sin_q[1];
			qc_s3 <= x_s2 * cos_q[1];
			y_s3  <= y_s2;
		end
		if (en4) begin
			z_s4 <= round_q30(SUM_W'(pc_s3) - SUM_W'(qs_s3));
			x_s4 <= round_q30(SUM_W'(ps_s3) + SUM_W'(qc_s3));
			y_s4 <= y_s3;
		end
		// z rotation products, p = x, q = y
		if (en5) begin
			pc_s5 <= x_s4 * cos_q[2];
			qs_s5 <= y_s4 * sin_q[2];
			ps_s5 <= x_s4 * sin_q[2];
			qc_s5 <= y_s4 * cos_q[2];
			z_s5  <= z_s4;
		end
		if (en6) begin
			x_s6 <= round_q30(SUM_W'(pc_s5) - SUM_W'(qs_s5));
			y_s6 <= round_q30(SUM_W'(ps_s5) + SUM_W'(qc_s5));
			z_s6 <= z_s5;
		end
		// saturation into the output register
		if (en7) begin
			out_s7.rot_x <= sat_coord(x_s6);
			out_s7.rot_y <= sat_coord(y_s6);
			out_s7.rot_z <= sat_coord(z_s6);
		end
	end

	assign out_valid = v_s7;
	assign out_data  = out_s7;

`ifndef SYNTHESIS
	// no request taken while the sine/cosine table is being rebuilt
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !busy_q)
		else $error("request accepted during trig update");

	// an angle write always restarts the sequencer
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> busy_q && step_q == 3'd0 && tidx_q == 3'd0)
		else $error("angle write did not restart trig sequencer");

	// the finished x-axis cosine stays within one
	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (cos_q[0] <= 32'sd1073741824 && cos_q[0] >= -32'sd1073741824))
		else $error("cosine out of range");
`endif

endmodule
